FILE: hdl/sws_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the sliding-window sender. No dependencies.
`default_nettype none
package sws_pkg;
    localparam int WINDOW_SIZE = 31;
    localparam int QDEPTH      = 31;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_MALFORM = 3'd2;
    localparam logic [2:0] ST_UNMATCH = 3'd3;
    localparam logic [2:0] ST_REFUSED = 3'd4;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_FB   = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    localparam logic [1:0] FB_DATA = 2'd0;
    localparam logic [1:0] FB_ACK  = 2'd1;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;

    typedef struct packed {
        logic       load;
        logic       send;
        logic       emit_code;
        logic [2:0] code;
        logic       ack_begin;
        logic       pop;
        logic       ack_match;
        logic       ack_miss;
        logic       scan_init;
        logic       scan_adv;
        logic       scan_take;
        logic       flush;
    } sws_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       malformed;
        logic       ignored;
        logic       early_miss;
        logic       count_one;
        logic       head_match;
        logic       scan_end;
        logic       cur_expired;
        logic       cand_valid;
        logic       out_free;
    } sws_stat_t;
endpackage
`default_nettype wire

FILE: hdl/sws_ctrl.sv
// Sequencing state machine of the sliding-window sender.
// Depends on sws_pkg; drives sws_datapath through sws_cmd_t.
`default_nettype none
module sws_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sws_pkg::sws_stat_t st,
    output sws_pkg::sws_cmd_t      cmd
);
    import sws_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_RETIRE, S_MATCH, S_MISS, S_SCAN, S_FLUSH}
        state_t;
    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (st.op)
                    OP_SEND: begin
                        if (st.out_free) begin
                            cmd.send = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_FB: begin
                        if (st.malformed || st.ignored) begin
                            if (st.out_free) begin
                                cmd.emit_code = 1'b1;
                                cmd.code = st.malformed ? ST_MALFORM : ST_IGNORED;
                                state_next = S_IDLE;
                            end
                        end else begin
                            cmd.ack_begin = 1'b1;
                            state_next = st.early_miss ? S_MISS : S_RETIRE;
                        end
                    end
                    OP_SCAN: begin
                        cmd.scan_init = 1'b1;
                        state_next = S_SCAN;
                    end
                    default: begin
                        if (st.out_free) begin
                            cmd.emit_code = 1'b1;
                            cmd.code = ST_IGNORED;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_RETIRE: begin
                cmd.pop = 1'b1;
                if (st.head_match)
                    state_next = S_MATCH;
                else if (st.count_one)
                    state_next = S_MISS;
            end
            S_MATCH: begin
                if (st.out_free) begin
                    cmd.ack_match = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MISS: begin
                if (st.out_free) begin
                    cmd.ack_miss = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (st.scan_end)
                    state_next = S_FLUSH;
                else if (st.cur_expired) begin
                    if (!st.cand_valid || st.out_free)
                        cmd.scan_take = 1'b1;
                end else
                    cmd.scan_adv = 1'b1;
            end
            S_FLUSH: begin
                if (!st.cand_valid || st.out_free) begin
                    cmd.flush = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_pop_in_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> state_reg == S_RETIRE)
        else $error("pop outside retire walk");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_DECIDE)
        else $error("load did not start decode");
    a_scan_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_take && st.cand_valid) |-> st.out_free)
        else $error("scan result pushed into full output");
endmodule
`default_nettype wire

FILE: hdl/sws_datapath.sv
// Window state, pending queue and result register of the sender.
// Depends on sws_pkg; commanded by sws_ctrl.
`default_nettype none
module sws_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sws_pkg::sws_cmd_t  cmd,
    output sws_pkg::sws_stat_t      st,
    input  wire logic [7:0]         timeout,
    input  wire logic [1:0]         in_op,
    input  wire logic [31:0]        in_now,
    input  wire logic               in_ok,
    input  wire logic [1:0]         in_type,
    input  wire logic               in_trunc,
    input  wire logic [7:0]         in_seq,
    input  wire logic [4:0]         in_win,
    input  wire logic [31:0]        in_stamp,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              out_status,
    output logic [7:0]              out_seq,
    output logic [7:0]              out_window,
    output logic                    out_resend,
    output logic                    out_last
);
    import sws_pkg::*;

    localparam logic [4:0] QD5 = 5'(QDEPTH);
    localparam logic [5:0] QD6 = 6'(QDEPTH);

    function automatic logic [4:0] slot(input logic [4:0] h, input logic [5:0] i);
        logic [5:0] s;
        s = {1'b0, h} + i;
        if (s >= QD6)
            s = s - QD6;
        return s[4:0];
    endfunction

    logic [1:0]  op_reg;
    logic [31:0] now_reg, stamp_reg;
    logic        ok_reg, trunc_reg;
    logic [1:0]  type_reg;
    logic [7:0]  seq_reg;
    logic [4:0]  win_reg;

    logic [7:0]  low_reg, high_reg, nseq_reg, pwin_reg, credit_reg;
    logic [4:0]  head_reg;
    logic [5:0]  count_reg, scan_i_reg;
    logic        cand_v_reg;
    logic [7:0]  cand_seq_reg;
    logic [7:0]  pseq_reg [QDEPTH];
    logic [31:0] ptime_reg [QDEPTH];

    logic        ov_reg, olast_reg, ores_reg;
    logic [2:0]  ost_reg;
    logic [7:0]  oseq_reg, owin_reg;

    logic [4:0]  rd_idx, tail_idx, head_nx;
    logic [7:0]  cur_seq, target, diff;
    logic [31:0] cur_time;
    logic        outside, refuse;
    logic [9:0]  credit_sum;
    logic [7:0]  credit_new;

    assign rd_idx   = slot(head_reg, scan_i_reg);
    assign tail_idx = slot(head_reg, count_reg);
    assign head_nx  = (head_reg == QD5 - 5'd1) ? 5'd0 : head_reg + 5'd1;
    assign cur_seq  = pseq_reg[rd_idx];
    assign cur_time = ptime_reg[rd_idx];
    assign target   = seq_reg - 8'd1;
    assign diff     = seq_reg - low_reg;
    assign credit_sum = {2'b0, credit_reg} + ((diff == 8'd0) ? 10'd256 : {2'b0, diff});
    assign credit_new = (credit_sum > 10'd255) ? 8'd255 : credit_sum[7:0];
    assign refuse = (pwin_reg == 8'd0) || (credit_reg == 8'd0) || (count_reg >= QD6);

    always_comb begin
        if (low_reg < high_reg)
            outside = (seq_reg < low_reg) || (seq_reg > high_reg);
        else
            outside = (high_reg < seq_reg) && (seq_reg < low_reg);
    end

    always_comb begin
        logic [7:0] hd;
        hd = cur_seq - target;
        st.op         = op_reg;
        st.malformed  = !ok_reg || (type_reg == FB_DATA) || trunc_reg;
        st.ignored    = outside || (type_reg != FB_ACK)
                        || ({1'b0, now_reg} > {1'b0, stamp_reg} + {25'd0, timeout});
        st.early_miss = (count_reg == 6'd0)
                        || ((low_reg < high_reg) && (cur_seq > target))
                        || ((high_reg < low_reg) && (cur_seq > target) && (hd < 8'd32));
        st.count_one  = (count_reg == 6'd1);
        st.head_match = (cur_seq == target);
        st.scan_end   = (scan_i_reg >= count_reg);
        st.cur_expired = {1'b0, now_reg} > {1'b0, cur_time} + {25'd0, timeout};
        st.cand_valid = cand_v_reg;
        st.out_free   = !ov_reg || out_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op;      now_reg <= in_now;    ok_reg <= in_ok;
            type_reg <= in_type;  trunc_reg <= in_trunc; seq_reg <= in_seq;
            win_reg <= in_win;    stamp_reg <= in_stamp;
        end
        if (cmd.send && !refuse) begin
            pseq_reg[tail_idx]  <= nseq_reg;
            ptime_reg[tail_idx] <= now_reg;
        end
        if (cmd.ack_miss && count_reg != 6'd0)
            ptime_reg[rd_idx] <= now_reg;
        if (cmd.scan_take) begin
            ptime_reg[rd_idx] <= now_reg;
            cand_seq_reg <= cur_seq;
        end
        if (cmd.send) begin
            ost_reg <= refuse ? ST_REFUSED : ST_DONE;
            oseq_reg <= refuse ? 8'd0 : nseq_reg;
            owin_reg <= credit_reg; ores_reg <= 1'b0; olast_reg <= 1'b1;
        end else if (cmd.emit_code) begin
            ost_reg <= cmd.code; oseq_reg <= 8'd0;
            owin_reg <= credit_reg; ores_reg <= 1'b0; olast_reg <= 1'b1;
        end else if (cmd.ack_match) begin
            ost_reg <= ST_DONE; oseq_reg <= 8'd0;
            owin_reg <= credit_new; ores_reg <= 1'b0; olast_reg <= 1'b1;
        end else if (cmd.ack_miss) begin
            ost_reg <= ST_UNMATCH;
            oseq_reg <= (count_reg != 6'd0) ? cur_seq : 8'd0;
            owin_reg <= credit_reg; ores_reg <= (count_reg != 6'd0); olast_reg <= 1'b1;
        end else if ((cmd.scan_take || cmd.flush) && cand_v_reg) begin
            ost_reg <= ST_DONE; oseq_reg <= cand_seq_reg;
            owin_reg <= credit_reg; ores_reg <= 1'b1; olast_reg <= cmd.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg <= 8'd0;
            high_reg <= 8'(WINDOW_SIZE % 256);
            nseq_reg <= 8'd0;
            pwin_reg <= 8'd1;
            credit_reg <= 8'(WINDOW_SIZE);
            head_reg <= 5'd0;
            count_reg <= 6'd0;
            scan_i_reg <= 6'd0;
            cand_v_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (cmd.send && !refuse) begin
                count_reg <= count_reg + 6'd1;
                nseq_reg <= nseq_reg + 8'd1;
                pwin_reg <= pwin_reg - 8'd1;
                credit_reg <= credit_reg - 8'd1;
            end
            if (cmd.ack_begin)
                pwin_reg <= {3'd0, win_reg};
            if (cmd.pop) begin
                head_reg <= head_nx;
                count_reg <= count_reg - 6'd1;
            end
            if (cmd.ack_match) begin
                credit_reg <= credit_new;
                low_reg <= seq_reg;
                high_reg <= seq_reg + 8'(WINDOW_SIZE % 256);
            end
            if (cmd.scan_init || cmd.flush) begin
                scan_i_reg <= 6'd0;
                cand_v_reg <= 1'b0;
            end
            if (cmd.scan_adv || cmd.scan_take)
                scan_i_reg <= scan_i_reg + 6'd1;
            if (cmd.scan_take)
                cand_v_reg <= 1'b1;
            if (cmd.send || cmd.emit_code || cmd.ack_match || cmd.ack_miss
                || ((cmd.scan_take || cmd.flush) && cand_v_reg))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_seq    = oseq_reg;
    assign out_window = owin_reg;
    assign out_resend = ores_reg;
    assign out_last   = olast_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QD6 && head_reg < QD5)
        else $error("queue pointers out of range");
    a_send_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.send && !refuse) |=> count_reg == $past(count_reg) + 6'd1)
        else $error("accepted send did not queue");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> count_reg != 6'd0)
        else $error("pop on empty queue");
endmodule
`default_nettype wire

FILE: hdl/sliding_window_sender.sv
// Top level of the sliding-window ARQ sender: stream ports, APB register,
// controller and datapath. Depends on sws_pkg, sws_ctrl, sws_datapath.
//
// One item at a time. Send, malformed or ignored feedback, and op 3 are
// decoded and answered from the decode state; an ACK that is refused before
// any entry is walked answers from the miss state. An ACK that walks the
// queue retires entries one per cycle, then answers from the match or miss
// state. A scan walks the queued entries one per cycle, holding while an
// expired entry waits on a busy output. Every answer may wait for the output.
// timeout_seconds sits at address 0.
`default_nettype none
module sliding_window_sender (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // now_time, fb_ok, fb_type, fb_truncated, fb_seqnum, fb_window, fb_timestamp
    input  wire logic [87:0] s_tdata,
    // op
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // seq_out, window_out, resend
    output logic [23:0]      m_tdata,
    // status
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sws_pkg::*;

    sws_cmd_t   cmd;
    sws_stat_t  st;
    logic [7:0] timeout_reg;
    logic [7:0] oseq, owin;
    logic       ores;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TIMEOUT) ? {24'd0, timeout_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            timeout_reg <= 8'd5;
        else if (psel && penable && pwrite && paddr == REG_TIMEOUT)
            timeout_reg <= pwdata[7:0];
    end

    sws_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .st(st), .cmd(cmd)
    );

    sws_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st), .timeout(timeout_reg),
        .in_op(s_tuser), .in_now(s_tdata[31:0]), .in_ok(s_tdata[32]),
        .in_type(s_tdata[34:33]), .in_trunc(s_tdata[35]), .in_seq(s_tdata[43:36]),
        .in_win(s_tdata[48:44]), .in_stamp(s_tdata[80:49]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_status(m_tuser),
        .out_seq(oseq), .out_window(owin), .out_resend(ores), .out_last(m_tlast)
    );

    assign m_tdata = {7'd0, ores, owin, oseq};
endmodule
`default_nettype wire

FILE: test/tb_arq_checker.sv
// Checker for the sliding-window sender: watches the input, result and APB
// transfers, predicts results per accepted item and compares. Depends on sws_pkg.
`timescale 1ns / 1ps
module tb_arq_checker
    import sws_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [87:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending_results,
    output int               result_count,
    output int               resend_count
);
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] seq;
        logic [7:0] credit;
        logic       resend;
        logic       last;
    } arq_result_t;

    arq_result_t expected_q[$];
    logic [7:0]  tmo;
    logic [7:0]  low_edge, high_edge, next_seq, peer_win, credit;
    logic [7:0]  q_seq [QDEPTH];
    logic [31:0] q_time[QDEPTH];
    int          head, count;

    assign pending_results = expected_q.size();

    function automatic int slot(int i);
        return (head + i) % QDEPTH;
    endfunction

    function automatic logic is_expired(logic [31:0] now, logic [31:0] stamp);
        return {32'd0, now} > ({32'd0, stamp} + 64'(tmo));
    endfunction

    function automatic void push_result(logic [2:0] st, logic [7:0] sq, logic rs,
                                        logic lst);
        arq_result_t r;
        r.status = st;
        r.seq    = sq;
        r.credit = credit;
        r.resend = rs;
        r.last   = lst;
        expected_q.push_back(r);
    endfunction

    // 0 on match, 1 on mismatch
    function automatic logic retire_through(logic [7:0] target);
        logic [7:0] h;
        if (count == 0) return 1'b1;
        h = q_seq[slot(0)];
        if (low_edge < high_edge && h > target) return 1'b1;
        if (high_edge < low_edge && h > target && 8'(h - target) < 32) return 1'b1;
        while (count > 0) begin
            h = q_seq[slot(0)];
            head = (head + 1) % QDEPTH;
            count--;
            if (h == target) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [87:0] d);
        logic [31:0] now, stamp;
        logic        ok, trunc, outside;
        logic [1:0]  typ;
        logic [7:0]  sq;
        logic [4:0]  win;
        int          k, c, last_idx;
        now   = d[31:0];
        ok    = d[32];
        typ   = d[34:33];
        trunc = d[35];
        sq    = d[43:36];
        win   = d[48:44];
        stamp = d[80:49];
        case (op)
            OP_SEND: begin
                if (peer_win == 0 || credit == 0 || count >= QDEPTH) begin
                    push_result(ST_REFUSED, 8'd0, 1'b0, 1'b1);
                end else begin
                    q_seq[slot(count)]  = next_seq;
                    q_time[slot(count)] = now;
                    count++;
                    push_result(ST_DONE, next_seq, 1'b0, 1'b1);
                    next_seq++;
                    peer_win--;
                    credit--;
                end
            end
            OP_FB: begin
                if (!ok || typ == FB_DATA || trunc) begin
                    push_result(ST_MALFORM, 8'd0, 1'b0, 1'b1);
                    return;
                end
                if (low_edge < high_edge) outside = sq < low_edge || sq > high_edge;
                else outside = high_edge < sq && sq < low_edge;
                if (outside || is_expired(now, stamp) || typ != FB_ACK) begin
                    push_result(ST_IGNORED, 8'd0, 1'b0, 1'b1);
                    return;
                end
                peer_win = 8'(win);
                if (retire_through(8'(sq - 8'd1))) begin
                    if (count > 0) begin
                        q_time[slot(0)] = now;
                        push_result(ST_UNMATCH, q_seq[slot(0)], 1'b1, 1'b1);
                    end else begin
                        push_result(ST_UNMATCH, 8'd0, 1'b0, 1'b1);
                    end
                    return;
                end
                if (sq > low_edge) c = int'(credit) + int'(sq - low_edge);
                else c = int'(credit) + 256 - int'(low_edge) + int'(sq);
                credit    = (c > 255) ? 8'd255 : 8'(c);
                low_edge  = sq;
                high_edge = 8'(sq + 8'(WINDOW_SIZE));
                push_result(ST_DONE, 8'd0, 1'b0, 1'b1);
            end
            OP_SCAN: begin
                last_idx = -1;
                for (k = 0; k < count; k++) begin
                    if (is_expired(now, q_time[slot(k)])) begin
                        q_time[slot(k)] = now;
                        push_result(ST_DONE, q_seq[slot(k)], 1'b1, 1'b0);
                        last_idx = expected_q.size() - 1;
                    end
                end
                if (last_idx >= 0) expected_q[last_idx].last = 1'b1;
            end
            default: push_result(ST_IGNORED, 8'd0, 1'b0, 1'b1);
        endcase
    endfunction

    always @(posedge aclk) begin
        arq_result_t exp_r;
        if (!aresetn) begin
            tmo = 8'd5; low_edge = 0; high_edge = 8'(WINDOW_SIZE); next_seq = 0;
            peer_win = 8'd1; credit = 8'(WINDOW_SIZE); head = 0; count = 0;
            fail_count <= 0; result_count <= 0; resend_count <= 0;
            expected_q.delete();
        end else begin
            // results first: a result never stems from an item taken this edge
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (m_tdata[16]) resend_count <= resend_count + 1;
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tuser != exp_r.status || m_tdata[7:0] != exp_r.seq ||
                        m_tdata[15:8] != exp_r.credit || m_tdata[16] != exp_r.resend ||
                        m_tlast != exp_r.last) begin
                        fail_count <= fail_count + 1;
                        if (m_tuser != exp_r.status)
                            $error("status exp %0d got %0d", exp_r.status, m_tuser);
                        if (m_tdata[7:0] != exp_r.seq)
                            $error("seq_out exp %0d got %0d", exp_r.seq, m_tdata[7:0]);
                        if (m_tdata[15:8] != exp_r.credit)
                            $error("window_out exp %0d got %0d", exp_r.credit,
                                   m_tdata[15:8]);
                        if (m_tdata[16] != exp_r.resend)
                            $error("resend exp %0d got %0d", exp_r.resend, m_tdata[16]);
                        if (m_tlast != exp_r.last)
                            $error("last exp %0d got %0d", exp_r.last, m_tlast);
                    end
                end
            end
            if (psel && penable && pwrite && paddr == REG_TIMEOUT) tmo = pwdata[7:0];
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
        end
    end
endmodule

FILE: test/tb_top.sv
// Testbench top for sliding_window_sender: clock, reset, APB writes, item
// stimulus and verdict. Depends on sws_pkg, tb_arq_checker and the block.
`timescale 1ns / 1ps
module tb_top;
    import sws_pkg::*;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending_results, result_count, resend_count;
    int          cycles, item_count;
    logic [31:0] clock_now;
    logic [7:0]  ack_seq;
    logic        stall_on;

    sliding_window_sender u_dut (.*);
    tb_arq_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls: with stall_on set, a random number of idle cycles before each transfer
    initial begin
        int w;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            w = stall_on ? $urandom_range(0, 15) : 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk iff m_tvalid);
        end
    end

    task automatic write_timeout(logic [7:0] v);
        psel <= 1; pwrite <= 1; paddr <= REG_TIMEOUT; pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk iff pending_results == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_item(logic [1:0] op, logic [31:0] now, logic ok, logic [1:0] typ,
                             logic trunc, logic [7:0] sq, logic [4:0] win,
                             logic [31:0] stamp, int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, stamp, win, sq, trunc, typ, ok, now};
        @(posedge aclk iff s_tready);
        item_count++;
    endtask

    function automatic int rgap();
        return stall_on ? $urandom_range(0, 15) : 0;
    endfunction

    task automatic good_ack(logic [7:0] sq);
        send_item(OP_FB, clock_now, 1, FB_ACK, 0, sq, 5'($urandom_range(0, 31)),
                  clock_now, rgap());
    endtask

    initial begin
        int i, r, n;
        cycles = 0; item_count = 0; clock_now = 100; ack_seq = 0; stall_on = 1;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset credit, refusals, malformed, out of window, op 3
        send_item(OP_SEND, clock_now, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SEND, clock_now, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_FB, clock_now, 0, FB_ACK, 0, 1, 31, clock_now, 0);
        send_item(OP_FB, clock_now, 1, FB_DATA, 0, 1, 31, clock_now, 0);
        send_item(OP_FB, clock_now, 1, FB_ACK, 1, 1, 31, clock_now, 0);
        send_item(OP_FB, clock_now, 1, FB_ACK, 0, 8'd200, 31, clock_now, 0);
        send_item(OP_FB, clock_now, 1, 2'd2, 0, 1, 31, clock_now, 0);
        send_item(OP_FB, clock_now, 1, 2'd3, 0, 1, 31, clock_now, 0);
        send_item(OP_FB, 32'hFFFF_FFFF, 1, FB_ACK, 0, 1, 31, 32'd0, 0);
        send_item(2'd3, 32'hFFFF_FFFF, 1, 2'd3, 1, 8'hFF, 5'h1F, 32'hFFFF_FFFF, 0);
        send_item(OP_FB, clock_now, 1, FB_ACK, 0, 1, 31, clock_now, 0);   // match
        send_item(OP_FB, clock_now, 1, FB_ACK, 0, 1, 31, clock_now, 0);   // unmatched, empty
        for (i = 0; i < 32; i++) send_item(OP_SEND, clock_now, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_FB, clock_now, 1, FB_ACK, 0, 5, 31, clock_now, 0);  // match, retires seqs 1 to 4
        send_item(OP_SCAN, clock_now + 6, 0, 0, 0, 0, 0, 0, 0);            // resend all
        send_item(OP_SCAN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_FB, 32'hFFFF_FFFF, 1, FB_ACK, 0, 8'd32, 0, 32'hFFFF_FFFF, 0);
        drain();
        write_timeout(8'd0);
        write_timeout(8'd255);
        ack_seq = 32;

        // random: mostly sends and in-window acks, some scans and noise
        for (n = 0; n < 130; n++) begin
            if (n == 60) begin
                drain();
                write_timeout(8'($urandom_range(0, 20)));
                stall_on = 0;
            end
            if (n == 90) begin
                drain();
                write_timeout(8'd3);
                stall_on = 1;
            end
            clock_now += $urandom_range(0, 4);
            r = $urandom_range(0, 99);
            if (r < 40) send_item(OP_SEND, clock_now, 1'($urandom), 2'($urandom),
                                  1'($urandom), 8'($urandom), 5'($urandom), $urandom,
                                  rgap());
            else if (r < 70) begin
                ack_seq = ack_seq + 8'($urandom_range(0, 6));
                good_ack(ack_seq);
            end else if (r < 80) begin
                send_item(OP_SCAN, clock_now, 1'($urandom), 2'($urandom), 1'($urandom),
                          8'($urandom), 5'($urandom), $urandom, rgap());
            end else if (r < 90) begin
                send_item(OP_FB, clock_now, 1'($urandom), 2'($urandom), 1'($urandom),
                          ack_seq + 8'($urandom_range(0, 40)), 5'($urandom),
                          clock_now - $urandom_range(0, 300), rgap());
            end else begin
                send_item(2'($urandom), $urandom, 1'($urandom), 2'($urandom),
                          1'($urandom), 8'($urandom), 5'($urandom), $urandom, rgap());
            end
        end

        drain();
        $display("Covered %0d items, %0d results (%0d resends), timeout set 0..255,",
                 item_count, result_count, resend_count);
        $display("sends, acks, scans, malformed/stale feedback and unused op.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
